### rtl/mrrf_pkg.sv
// ---------------------------------------------------------------------------
// mrrf_pkg
// types, codes and constants shared by the modbus rtu request framer
// ---------------------------------------------------------------------------
`default_nettype none

package mrrf_pkg;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_SINGLE = 2'd1,
    KIND_MULTI  = 2'd2,
    KIND_DATA   = 2'd3
  } kind_t;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK         = 2'd0;
  localparam status_t ST_TOO_LONG   = 2'd1;
  localparam status_t ST_UNEXPECTED = 2'd2;

  localparam logic [7:0]  FN_READ_HOLDING = 8'd3;
  localparam logic [7:0]  FN_WRITE_SINGLE = 8'd6;
  localparam logic [7:0]  FN_WRITE_MULTI  = 8'd16;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;

  localparam int unsigned WORDS_W = 7;

  // one classified request as handed from the front to the back
  typedef struct packed {
    logic [6:0][7:0] bytes;     // frame bytes, element 0 goes out first
    logic [2:0]      nbytes;    // number of bytes before any crc
    logic            restart;   // start crc from its initial value
    logic            with_crc;  // append crc and close the frame
    status_t         status;    // non-ok means a single error result
  } cmd_t;

endpackage

`default_nettype wire

### rtl/mrrf_front.sv
// ---------------------------------------------------------------------------
// mrrf_front
// accepts request items, tracks the open write multiple frame and
// turns each item into a byte command for the back end
// ---------------------------------------------------------------------------
`default_nettype none

module mrrf_front import mrrf_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire kind_t       kind,
  input  wire logic [7:0]  slave_id,
  input  wire logic [15:0] register_address,
  input  wire logic [15:0] quantity,
  input  wire logic [15:0] data_word,
  output cmd_t             cmd
);

  localparam logic [16:0] LIMIT = 17'(MAX_FRAME_BYTES - 9);

  logic               pending_r, pending_nxt;
  logic [WORDS_W-1:0] words_r, words_nxt;
  logic               too_long;
  logic               accept;

  assign accept   = in_valid && in_ready;
  assign too_long = {quantity, 1'b0} > LIMIT;

  always_comb begin
    cmd          = '0;
    cmd.status   = ST_OK;
    pending_nxt  = pending_r;
    words_nxt    = words_r;
    case (kind)
      KIND_READ, KIND_SINGLE: begin
        cmd.bytes[0] = slave_id;
        cmd.bytes[1] = (kind == KIND_READ) ? FN_READ_HOLDING : FN_WRITE_SINGLE;
        cmd.bytes[2] = register_address[15:8];
        cmd.bytes[3] = register_address[7:0];
        cmd.bytes[4] = (kind == KIND_READ) ? quantity[15:8] : data_word[15:8];
        cmd.bytes[5] = (kind == KIND_READ) ? quantity[7:0] : data_word[7:0];
        cmd.nbytes   = 3'd6;
        cmd.restart  = 1'b1;
        cmd.with_crc = 1'b1;
        pending_nxt  = 1'b0;
        words_nxt    = '0;
      end
      KIND_MULTI: begin
        pending_nxt = 1'b0;
        words_nxt   = '0;
        if (too_long) begin
          cmd.status = ST_TOO_LONG;
        end else begin
          cmd.bytes[0] = slave_id;
          cmd.bytes[1] = FN_WRITE_MULTI;
          cmd.bytes[2] = register_address[15:8];
          cmd.bytes[3] = register_address[7:0];
          cmd.bytes[4] = quantity[15:8];
          cmd.bytes[5] = quantity[7:0];
          cmd.bytes[6] = {quantity[6:0], 1'b0};
          cmd.nbytes   = 3'd7;
          cmd.restart  = 1'b1;
          cmd.with_crc = (quantity == 16'd0);
          if (quantity != 16'd0) begin
            pending_nxt = 1'b1;
            words_nxt   = quantity[WORDS_W-1:0];
          end
        end
      end
      KIND_DATA: begin
        if (!pending_r) begin
          cmd.status = ST_UNEXPECTED;
        end else begin
          cmd.bytes[0] = data_word[15:8];
          cmd.bytes[1] = data_word[7:0];
          cmd.nbytes   = 3'd2;
          cmd.with_crc = (words_r == WORDS_W'(1));
          words_nxt    = words_r - WORDS_W'(1);
          // last word owed closes the frame
          if (words_r == WORDS_W'(1)) begin
            pending_nxt = 1'b0;
          end
        end
      end
      default: begin
        cmd.status = ST_UNEXPECTED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      words_r   <= '0;
    end else if (accept) begin
      pending_r <= pending_nxt;
      words_r   <= words_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/mrrf_queue.sv
// ---------------------------------------------------------------------------
// mrrf_queue
// two-entry command queue between the front and the back end
// ---------------------------------------------------------------------------
`default_nettype none

module mrrf_queue import mrrf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      not_full,
  input  wire logic pop,
  output cmd_t      head,
  output logic      not_empty
);

  cmd_t       entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign not_full  = (count_r != 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/mrrf_back.sv
// ---------------------------------------------------------------------------
// mrrf_back
// plays out one command as a byte stream, one byte a cycle while the output
// is ready, keeping the running crc-16 and appending it low byte first
// ---------------------------------------------------------------------------
`default_nettype none

module mrrf_back import mrrf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cmd_t       head,
  input  wire logic       head_valid,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      tx_byte,
  output logic            frame_end,
  output status_t         status
);

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  logic        out_valid_r;
  logic [7:0]  byte_r;
  logic        end_r;
  status_t     status_r;
  logic [3:0]  idx_r;
  logic [15:0] crc_r;

  logic        advance, step, is_err, is_data, is_last;
  logic [3:0]  last_idx;
  logic [15:0] crc_cur;
  logic [7:0]  byte_sel;

  assign advance  = !out_valid_r || out_ready;
  assign step     = head_valid && advance;
  assign is_err   = (head.status != ST_OK);
  assign is_data  = (idx_r < {1'b0, head.nbytes});
  assign last_idx = head.with_crc ? ({1'b0, head.nbytes} + 4'd1)
                                  : ({1'b0, head.nbytes} - 4'd1);
  assign is_last  = is_err || (idx_r == last_idx);
  assign crc_cur  = (idx_r == 4'd0 && head.restart) ? CRC_INIT : crc_r;
  assign pop      = step && is_last;

  always_comb begin
    if (is_err) begin
      byte_sel = 8'd0;
    end else if (is_data) begin
      byte_sel = head.bytes[idx_r[2:0]];
    end else if (idx_r == {1'b0, head.nbytes}) begin
      byte_sel = crc_cur[7:0];
    end else begin
      byte_sel = crc_cur[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 4'd0;
      crc_r       <= CRC_INIT;
    end else if (step) begin
      out_valid_r <= 1'b1;
      if (!is_err && is_data) begin
        crc_r <= crc_byte(crc_cur, byte_sel);
      end
      if (is_last) begin
        idx_r <= 4'd0;
        if (!is_err && head.with_crc) begin
          crc_r <= CRC_INIT;
        end
      end else begin
        idx_r <= idx_r + 4'd1;
      end
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      byte_r   <= byte_sel;
      end_r    <= is_err || (head.with_crc && is_last);
      status_r <= head.status;
    end
  end

  assign out_valid = out_valid_r;
  assign tx_byte   = byte_r;
  assign frame_end = end_r;
  assign status    = status_r;

endmodule

`default_nettype wire

### rtl/modbus_rtu_request_framer_top.sv
// ---------------------------------------------------------------------------
// modbus_rtu_request_framer_top
// modbus rtu master request framer with crc-16/modbus
// ---------------------------------------------------------------------------
// Each accepted request item yields its frame bytes on the output stream at
// one byte per cycle: eight for read holding and write single, seven for a
// write multiple header (nine with a quantity of zero), two per data word
// (four on the last), and one error result for a rejected item. out_tready
// and the back-end byte sequencer set the pace; a two-entry command queue
// lets the input take the next items while earlier frames still stream, so a
// steady stream of requests runs at one output byte every cycle. The crc is
// appended low byte first and tlast marks the last byte of a frame.
// ---------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_request_framer_top import mrrf_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,   // slave_id, register_address, quantity, data_word
  input  wire logic [1:0]  in_tuser,   // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // tx_byte
  output logic             out_tlast,  // frame_end
  output logic [1:0]       out_tuser   // status
);

  cmd_t    push_cmd, head;
  logic    q_not_full, q_not_empty, pop;
  status_t status;

  assign in_tready = q_not_full;

  mrrf_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_tvalid),
    .in_ready        (q_not_full),
    .kind            (kind_t'(in_tuser)),
    .slave_id        (in_tdata[7:0]),
    .register_address(in_tdata[23:8]),
    .quantity        (in_tdata[39:24]),
    .data_word       (in_tdata[55:40]),
    .cmd             (push_cmd)
  );

  mrrf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_tvalid && q_not_full),
    .push_cmd (push_cmd),
    .not_full (q_not_full),
    .pop      (pop),
    .head     (head),
    .not_empty(q_not_empty)
  );

  mrrf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .head_valid(q_not_empty),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .tx_byte   (out_tdata),
    .frame_end (out_tlast),
    .status    (status)
  );

  assign out_tuser = status;

`ifndef SYNTHESIS
  // an error result is a lone zero byte that closes the frame
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_OK) |-> (out_tlast && out_tdata == 8'd0))
    else $error("error result not a closing zero byte");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // the queue cannot be full while nothing waits at its head
  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> q_not_empty)
    else $error("queue full but empty");
`endif

endmodule

`default_nettype wire

### test/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for the modbus rtu request framer
// ---------------------------------------------------------------------------
// Request items go in on the input stream and every frame byte that comes out
// is compared with a model of the framer kept in the bench: the crc-16/modbus,
// the open write multiple frame and the two error results. A directed table
// covers field extremes, every request kind, the zero quantity header, the
// frame size limit, abandoned frames and stray data words. Random request
// sequences follow, mostly well-formed write multiple frames. Both streams
// idle at random and the sender drains the output once midway.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
  import mrrf_pkg::*;

  localparam int unsigned FRAME_LIMIT = 256;
  localparam int          RANDOM_ITEMS = 436;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  id;
    logic [15:0] addr;
    logic [15:0] qty;
    logic [15:0] word;
  } request_t;

  typedef struct packed {
    logic [7:0] txb;
    logic       last;
    status_t    st;
  } frame_byte_t;

  // typed rows carry their single error result directly
  typedef struct packed {
    request_t req;
    logic     typed;
    status_t  typed_st;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;   // slave_id, register_address, quantity, data_word
  logic [1:0]  in_tuser;   // kind
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // tx_byte
  logic        out_tlast;  // frame_end
  logic [1:0]  out_tuser;  // status

  modbus_rtu_request_framer_top #(
    .MAX_FRAME_BYTES(FRAME_LIMIT)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  // model state of the framer
  logic [15:0] open_crc;
  logic [6:0]  words_owed;
  bit          frame_open;

  frame_byte_t frame_bytes_q[$];

  int n_fail;
  int n_items;
  int n_bytes;
  int n_frames;
  int n_too_long;
  int n_unexpected;
  bit in_rush;
  bit out_rush;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [15:0] crc16_modbus(logic [15:0] crc, logic [7:0] b);
    crc = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
    end
    return crc;
  endfunction

  task automatic put_byte(logic [7:0] b, logic last, status_t st, bit record);
    frame_byte_t fb;
    fb.txb  = b;
    fb.last = last;
    fb.st   = st;
    if (record) frame_bytes_q.push_back(fb);
  endtask

  // works out the bytes one request causes and moves the model state on
  task automatic predict_request(request_t r, bit record);
    logic [7:0]  fb [0:6];
    int          nb;
    logic [15:0] crc;
    bit          closes;
    crc    = CRC_INIT;
    nb     = 0;
    closes = 1'b0;
    if (r.kind == KIND_DATA) begin
      if (!frame_open) begin
        put_byte(8'h00, 1'b1, ST_UNEXPECTED, record);
        return;
      end
      words_owed = words_owed - 7'd1;
      fb[0]  = r.word[15:8];
      fb[1]  = r.word[7:0];
      nb     = 2;
      closes = (words_owed == 7'd0);
      crc    = open_crc;
    end else begin
      // a new request drops whatever frame was open
      frame_open = 1'b0;
      words_owed = 7'd0;
      open_crc   = CRC_INIT;
      fb[0] = r.id;
      fb[2] = r.addr[15:8];
      fb[3] = r.addr[7:0];
      if (r.kind == KIND_MULTI && 32'(r.qty) * 2 > FRAME_LIMIT - 9) begin
        put_byte(8'h00, 1'b1, ST_TOO_LONG, record);
        return;
      end
      case (r.kind)
        KIND_READ: begin
          fb[1]  = FN_READ_HOLDING;
          fb[4]  = r.qty[15:8];
          fb[5]  = r.qty[7:0];
          nb     = 6;
          closes = 1'b1;
        end
        KIND_SINGLE: begin
          fb[1]  = FN_WRITE_SINGLE;
          fb[4]  = r.word[15:8];
          fb[5]  = r.word[7:0];
          nb     = 6;
          closes = 1'b1;
        end
        default: begin
          fb[1]  = FN_WRITE_MULTI;
          fb[4]  = r.qty[15:8];
          fb[5]  = r.qty[7:0];
          fb[6]  = {r.qty[6:0], 1'b0};
          nb     = 7;
          closes = (r.qty == 16'd0);
        end
      endcase
    end
    for (int i = 0; i < nb; i++) begin
      crc = crc16_modbus(crc, fb[i]);
      put_byte(fb[i], 1'b0, ST_OK, record);
    end
    if (closes) begin
      put_byte(crc[7:0], 1'b0, ST_OK, record);
      put_byte(crc[15:8], 1'b1, ST_OK, record);
      frame_open = 1'b0;
      open_crc   = CRC_INIT;
    end else begin
      open_crc = crc;
      if (r.kind == KIND_MULTI) begin
        frame_open = 1'b1;
        words_owed = r.qty[6:0];
      end
    end
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_request(request_t r, bit record);
    int gap;
    if ($urandom_range(0, 19) == 0) in_rush = !in_rush;
    gap = in_rush ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {r.word, r.qty, r.addr, r.id};
    in_tuser  = r.kind;
    do @(posedge clk); while (!in_tready);
    predict_request(r, record);
    n_items++;
    @(negedge clk);
  endtask

  function automatic request_t random_request(kind_t k);
    request_t r;
    r.kind = k;
    r.id   = 8'($urandom_range(0, 255));
    r.addr = 16'($urandom_range(0, 65535));
    r.qty  = 16'($urandom_range(0, 65535));
    r.word = 16'($urandom_range(0, 65535));
    return r;
  endfunction

  row_t dir_table [0:23];

  initial begin
    request_t r;
    int       sel;
    int       words;
    bit       drained;
    frame_byte_t typed_fb;

    dir_table = '{
      '{'{KIND_DATA,   8'h11, 16'h2222, 16'h3333, 16'h4444}, 1'b1, ST_UNEXPECTED},
      '{'{KIND_READ,   8'h00, 16'h0000, 16'h0000, 16'h0000}, 1'b0, ST_OK},
      '{'{KIND_READ,   8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, ST_OK},
      '{'{KIND_SINGLE, 8'h01, 16'h1234, 16'h5678, 16'hFFFF}, 1'b0, ST_OK},
      '{'{KIND_SINGLE, 8'hFF, 16'h0000, 16'hFFFF, 16'h0000}, 1'b0, ST_OK},
      '{'{KIND_MULTI,  8'h0A, 16'h0100, 16'h0000, 16'h0000}, 1'b0, ST_OK},
      '{'{KIND_MULTI,  8'h0A, 16'h0100, 16'h007C, 16'h0000}, 1'b1, ST_TOO_LONG},
      '{'{KIND_MULTI,  8'h0A, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, ST_TOO_LONG},
      '{'{KIND_MULTI,  8'h05, 16'h0010, 16'h0001, 16'h0000}, 1'b0, ST_OK},
      '{'{KIND_DATA,   8'h00, 16'h0000, 16'h0000, 16'hFFFF}, 1'b0, ST_OK},
      '{'{KIND_DATA,   8'h00, 16'h0000, 16'h0000, 16'h1111}, 1'b1, ST_UNEXPECTED},
      '{'{KIND_MULTI,  8'h07, 16'h0040, 16'h0003, 16'h0000}, 1'b0, ST_OK},
      '{'{KIND_DATA,   8'h00, 16'h0000, 16'h0000, 16'h0000}, 1'b0, ST_OK},
      '{'{KIND_DATA,   8'h00, 16'h0000, 16'h0000, 16'hA5A5}, 1'b0, ST_OK},
      '{'{KIND_DATA,   8'h00, 16'h0000, 16'h0000, 16'hFFFF}, 1'b0, ST_OK},
      '{'{KIND_MULTI,  8'h20, 16'h00FF, 16'h007B, 16'h0000}, 1'b0, ST_OK},
      '{'{KIND_DATA,   8'h00, 16'h0000, 16'h0000, 16'h1357}, 1'b0, ST_OK},
      '{'{KIND_READ,   8'h01, 16'h0000, 16'h000A, 16'h0000}, 1'b0, ST_OK},
      '{'{KIND_DATA,   8'h00, 16'h0000, 16'h0000, 16'h2468}, 1'b1, ST_UNEXPECTED},
      '{'{KIND_MULTI,  8'h02, 16'h8000, 16'h0002, 16'h0000}, 1'b0, ST_OK},
      '{'{KIND_DATA,   8'h00, 16'h0000, 16'h0000, 16'h00FF}, 1'b0, ST_OK},
      '{'{KIND_MULTI,  8'h02, 16'h8001, 16'h0002, 16'h0000}, 1'b0, ST_OK},
      '{'{KIND_DATA,   8'h00, 16'h0000, 16'h0000, 16'h0102}, 1'b0, ST_OK},
      '{'{KIND_DATA,   8'h00, 16'h0000, 16'h0000, 16'h0304}, 1'b0, ST_OK}
    };

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    open_crc   = CRC_INIT;
    words_owed = 7'd0;
    frame_open = 1'b0;
    n_fail     = 0;
    n_items    = 0;
    in_rush    = 1'b0;
    drained    = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_table[i]) begin
      if (dir_table[i].typed) begin
        typed_fb.txb  = 8'h00;
        typed_fb.last = 1'b1;
        typed_fb.st   = dir_table[i].typed_st;
        frame_bytes_q.push_back(typed_fb);
      end
      send_request(dir_table[i].req, !dir_table[i].typed);
    end

    while (n_items < RANDOM_ITEMS + 24) begin
      if (!drained && n_items >= 260) begin
        // hold the input off until every byte owed has come out
        in_tvalid = 1'b0;
        while (frame_bytes_q.size() != 0) @(negedge clk);
        drained = 1'b1;
      end
      sel = $urandom_range(0, 99);
      if (sel < 18) begin
        send_request(random_request(KIND_READ), 1'b1);
      end else if (sel < 33) begin
        send_request(random_request(KIND_SINGLE), 1'b1);
      end else if (sel < 80) begin
        r = random_request(KIND_MULTI);
        r.qty = ($urandom_range(0, 29) == 0) ? 16'($urandom_range(100, 123))
                                             : 16'($urandom_range(0, 8));
        words = r.qty;
        // now and then the frame is cut short by the next request
        if (words > 0 && $urandom_range(0, 7) == 0) words = $urandom_range(0, words - 1);
        send_request(r, 1'b1);
        for (int w = 0; w < words; w++) begin
          send_request(random_request(KIND_DATA), 1'b1);
        end
      end else if (sel < 88) begin
        r = random_request(KIND_MULTI);
        r.qty = 16'($urandom_range(124, 65535));
        send_request(r, 1'b1);
      end else begin
        send_request(random_request(kind_t'($urandom_range(0, 3))), 1'b1);
      end
    end
    in_tvalid = 1'b0;

    while (frame_bytes_q.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);

    $display("%0d request items sent, %0d bytes checked, %0d frames closed", n_items,
             n_bytes, n_frames);
    $display("error results: %0d frame too long, %0d stray data word", n_too_long,
             n_unexpected);
    if (n_fail == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // receiver side back-pressure
  initial begin
    int stall;
    out_tready = 1'b0;
    out_rush   = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) out_rush = !out_rush;
      stall = out_rush ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    frame_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_bytes++;
      if (out_tlast && out_tuser == ST_OK) n_frames++;
      if (out_tuser == ST_TOO_LONG) n_too_long++;
      if (out_tuser == ST_UNEXPECTED) n_unexpected++;
      if (frame_bytes_q.size() == 0) begin
        n_fail++;
        $display("%0t: item with nothing expected: byte %02h last %0b status %0d", $time,
                 out_tdata, out_tlast, out_tuser);
      end else begin
        want = frame_bytes_q.pop_front();
        if (out_tdata !== want.txb) begin
          n_fail++;
          $display("%0t: tx byte expected %02h actual %02h", $time, want.txb, out_tdata);
        end
        if (out_tlast !== want.last) begin
          n_fail++;
          $display("%0t: frame end expected %0b actual %0b", $time, want.last, out_tlast);
        end
        if (out_tuser !== want.st) begin
          n_fail++;
          $display("%0t: status expected %0d actual %0d", $time, want.st, out_tuser);
        end
      end
    end
  end

endmodule

`default_nettype wire

### sim.f
rtl/mrrf_pkg.sv
rtl/mrrf_front.sv
rtl/mrrf_queue.sv
rtl/mrrf_back.sv
rtl/modbus_rtu_request_framer_top.sv
test/testbench.sv
